/* design/clpg_pkg.sv */
`timescale 1ns / 1ps
// clpg_pkg: constants, codes, command and status types and coefficient functions
// for the clothoid point generator; used by every file of the block but clpg_if and clpg_mul

package clpg_pkg;

  localparam int TERMS        = 30;
  localparam int MAX_SEGMENTS = 4095;
  localparam int KW           = $clog2(TERMS);
  localparam int CFG_IDX_W    = 3;
  localparam int DVS_W        = 24;
  localparam int COEF_W       = 8;
  localparam int PC_W         = 5;
  localparam int DIV_STEP     = 4;
  localparam int DIV_ITERS    = 64 / DIV_STEP;
  localparam int DIV_CNT_W    = $clog2(DIV_ITERS);

  localparam logic signed [63:0] HALF_PI_Q40 = 64'sd1727108826179;
  localparam logic signed [63:0] T_LIMIT     = 64'sd536870912;

  localparam logic [KW-1:0]   K_LAST      = KW'(TERMS - 2);
  localparam logic [PC_W-1:0] PC_LOOP     = 5'd9;
  localparam logic [PC_W-1:0] PC_LOOP_END = 5'd12;
  localparam logic [PC_W-1:0] PC_LAST     = 5'd16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCALE    = 3'd0,
    REG_X_OFFSET = 3'd1,
    REG_Y_OFFSET = 3'd2,
    REG_START    = 3'd3,
    REG_END      = 3'd4,
    REG_SEGMENTS = 3'd5
  } cfg_reg_t;

  typedef enum logic [2:0] {
    OP_DIFF  = 3'd0,
    OP_TDIV  = 3'd1,
    OP_MUL   = 3'd2,
    OP_DIV3  = 3'd3,
    OP_KDIVC = 3'd4,
    OP_KDIVS = 3'd5,
    OP_FINX  = 3'd6,
    OP_FINY  = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    A_T40   = 3'd0,
    A_T2    = 3'd1,
    A_TMP   = 3'd2,
    A_TC    = 3'd3,
    A_TS    = 3'd4,
    A_SCALE = 3'd5
  } asel_t;

  typedef enum logic [2:0] {
    B_T40 = 3'd0,
    B_T2  = 3'd1,
    B_HP  = 3'd2,
    B_W   = 3'd3,
    B_SC  = 3'd4,
    B_SS  = 3'd5
  } bsel_t;

  typedef enum logic [1:0] {
    D_T2  = 2'd0,
    D_TMP = 2'd1,
    D_W   = 2'd2
  } dst_t;

  typedef struct packed {
    op_t   op;
    asel_t asel;
    bsel_t bsel;
    dst_t  dst;
  } uop_t;

  typedef struct packed {
    logic          load;
    logic          start;
    logic          emit;
    uop_t          uop;
    logic [KW-1:0] k;
  } ctl_cmd_t;

  typedef struct packed {
    logic done;
    logic out_free;
  } dp_stat_t;

  function automatic uop_t ucode(input logic [PC_W-1:0] pc);
    uop_t u;
    u = '{op: OP_MUL, asel: A_TMP, bsel: B_HP, dst: D_TMP};
    case (pc)
      5'd0:  u.op = OP_DIFF;
      5'd1:  u.op = OP_TDIV;
      5'd2:  u = '{op: OP_MUL, asel: A_T40, bsel: B_T40, dst: D_T2};
      5'd3:  u = '{op: OP_MUL, asel: A_T2, bsel: B_T2, dst: D_TMP};
      5'd4:  u = '{op: OP_MUL, asel: A_TMP, bsel: B_HP, dst: D_TMP};
      5'd5:  u = '{op: OP_MUL, asel: A_TMP, bsel: B_HP, dst: D_W};
      5'd6:  u = '{op: OP_MUL, asel: A_T2, bsel: B_T40, dst: D_TMP};
      5'd7:  u = '{op: OP_MUL, asel: A_TMP, bsel: B_HP, dst: D_TMP};
      5'd8:  u.op = OP_DIV3;
      5'd9:  u = '{op: OP_MUL, asel: A_TC, bsel: B_W, dst: D_TMP};
      5'd10: u.op = OP_KDIVC;
      5'd11: u = '{op: OP_MUL, asel: A_TS, bsel: B_W, dst: D_TMP};
      5'd12: u.op = OP_KDIVS;
      5'd13: u = '{op: OP_MUL, asel: A_SCALE, bsel: B_SC, dst: D_TMP};
      5'd14: u.op = OP_FINX;
      5'd15: u = '{op: OP_MUL, asel: A_SCALE, bsel: B_SS, dst: D_TMP};
      5'd16: u.op = OP_FINY;
      default: u.op = OP_FINY;
    endcase
    return u;
  endfunction

  function automatic logic [COEF_W-1:0] coef_c(input logic [KW-1:0] k);
    return COEF_W'(4 * int'(k) + 1);
  endfunction

  function automatic logic [COEF_W-1:0] coef_s(input logic [KW-1:0] k);
    return COEF_W'(4 * int'(k) + 3);
  endfunction

  function automatic logic [DVS_W-1:0] den_c(input logic [KW-1:0] k);
    return DVS_W'((2 * int'(k) + 1) * (2 * int'(k) + 2) * (4 * int'(k) + 5));
  endfunction

  function automatic logic [DVS_W-1:0] den_s(input logic [KW-1:0] k);
    return DVS_W'((2 * int'(k) + 2) * (2 * int'(k) + 3) * (4 * int'(k) + 7));
  endfunction

endpackage

/* design/clpg_if.sv */
`timescale 1ns / 1ps
// clpg_in_if and clpg_out_if: valid/ready channels of the clothoid point generator
// no dependencies

interface clpg_in_if;
  logic        valid;
  logic        ready;
  logic [11:0] sample_index;

  modport source (output valid, output sample_index, input ready);
  modport sink (input valid, input sample_index, output ready);
endinterface

interface clpg_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] box_min_x;
  logic signed [31:0] box_min_y;
  logic signed [31:0] box_max_x;
  logic signed [31:0] box_max_y;

  modport source (output valid, output point_x, output point_y, output box_min_x,
                  output box_min_y, output box_max_x, output box_max_y, input ready);
  modport sink (input valid, input point_x, input point_y, input box_min_x,
                input box_min_y, input box_max_x, input box_max_y, output ready);
endinterface

/* design/clothoid_point_generator_top.sv */
`timescale 1ns / 1ps
// clothoid_point_generator_top: clothoid point and bounding box generator
// depends on clpg_pkg, clpg_if, clpg_ctrl, clpg_dp

// One sample index in, one point with the running bounding box out. Every series term
// costs two passes of the shared 32x32 multiplier (four partial products a pass) and
// two passes of the shared divider (four quotient bits a cycle), one of each for the
// cosine and one for the sine series. A result waiting in the output register stalls
// the end of the next item. A new index is taken as soon as the previous result sits
// in the output register, even if it has not been taken yet. Configuration writes take
// effect at once and belong between items.

module clothoid_point_generator_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [clpg_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [31:0]                    cfg_data,
  clpg_in_if.sink                        in_ch,
  clpg_out_if.source                     out_ch
);

  clpg_pkg::ctl_cmd_t cmd;
  clpg_pkg::dp_stat_t st;

  clpg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .cmd      (cmd),
    .st       (st)
  );

  clpg_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_idx      (cfg_idx),
    .cfg_data     (cfg_data),
    .sample_index (in_ch.sample_index),
    .cmd          (cmd),
    .st           (st),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .point_x      (out_ch.point_x),
    .point_y      (out_ch.point_y),
    .box_min_x    (out_ch.box_min_x),
    .box_min_y    (out_ch.box_min_y),
    .box_max_x    (out_ch.box_max_x),
    .box_max_y    (out_ch.box_max_y)
  );

endmodule

/* design/clpg_mul.sv */
`timescale 1ns / 1ps
// clpg_mul: signed 64x64 product truncated to Q.40, one 32x32 partial product per cycle
// no dependencies

module clpg_mul (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [63:0] a,
  input  logic signed [63:0] b,
  output logic signed [63:0] product,
  output logic               done
);

  logic [63:0]  am_r, bm_r;
  logic         neg_r;
  logic [127:0] acc_r, acc_nxt;
  logic [1:0]   cnt_r;
  logic         busy_r, fin_r;
  logic [31:0]  ah, bh;
  logic [63:0]  pp, r;
  logic [1:0]   hs;

  always_comb begin
    ah      = cnt_r[1] ? am_r[63:32] : am_r[31:0];
    bh      = cnt_r[0] ? bm_r[63:32] : bm_r[31:0];
    pp      = 64'(ah) * 64'(bh);
    hs      = {1'b0, cnt_r[1]} + {1'b0, cnt_r[0]};
    acc_nxt = acc_r + ({64'b0, pp} << {hs, 5'b0});
    r       = acc_r[103] ? 64'h7FFF_FFFF_FFFF_FFFF : acc_r[103:40];
    product = neg_r ? -$signed(r) : $signed(r);
    done    = fin_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      cnt_r  <= '0;
    end else begin
      fin_r <= busy_r && (cnt_r == 2'd3);
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 2'd1;
        if (cnt_r == 2'd3) busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      am_r  <= a[63] ? 64'(-a) : 64'(a);
      bm_r  <= b[63] ? 64'(-b) : 64'(b);
      neg_r <= a[63] ^ b[63];
      acc_r <= '0;
    end else if (busy_r) begin
      acc_r <= acc_nxt;
    end
  end

endmodule

/* design/clpg_div.sv */
`timescale 1ns / 1ps
// clpg_div: unsigned 64-bit by narrow divisor, restoring, four quotient bits per cycle
// depends on clpg_pkg

module clpg_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [63:0]                dividend,
  input  logic [clpg_pkg::DVS_W-1:0] divisor,
  output logic [63:0]                quotient,
  output logic                       done
);

  localparam logic [clpg_pkg::DIV_CNT_W-1:0] CNT_LAST =
    clpg_pkg::DIV_CNT_W'(clpg_pkg::DIV_ITERS - 1);

  logic [clpg_pkg::DVS_W-1:0]     rem_r, rem_nxt, dvs_r;
  logic [63:0]                    quo_r, quo_nxt;
  logic [clpg_pkg::DIV_CNT_W-1:0] cnt_r;
  logic                           busy_r, fin_r;

  always_comb begin
    logic [clpg_pkg::DVS_W-1:0] rem;
    logic [clpg_pkg::DVS_W:0]   trial;
    logic [63:0]                quo;
    rem = rem_r;
    quo = quo_r;
    for (int j = 0; j < clpg_pkg::DIV_STEP; j++) begin
      trial = {rem, quo[63]};
      quo   = {quo[62:0], 1'b0};
      if (trial >= {1'b0, dvs_r}) begin
        rem    = clpg_pkg::DVS_W'(trial - {1'b0, dvs_r});
        quo[0] = 1'b1;
      end else begin
        rem = trial[clpg_pkg::DVS_W-1:0];
      end
    end
    rem_nxt  = rem;
    quo_nxt  = quo;
    quotient = quo_r;
    done     = fin_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      cnt_r  <= '0;
    end else begin
      fin_r <= busy_r && (cnt_r == CNT_LAST);
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

endmodule

/* design/clpg_dp.sv */
`timescale 1ns / 1ps
// clpg_dp: configuration registers, working registers, shared multiplier and divider,
// bounding box and output register; depends on clpg_pkg, clpg_mul, clpg_div

module clpg_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [clpg_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [31:0]                    cfg_data,
  input  logic [11:0]                    sample_index,
  input  clpg_pkg::ctl_cmd_t             cmd,
  output clpg_pkg::dp_stat_t             st,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [31:0]             point_x,
  output logic signed [31:0]             point_y,
  output logic signed [31:0]             box_min_x,
  output logic signed [31:0]             box_min_y,
  output logic signed [31:0]             box_max_x,
  output logic signed [31:0]             box_max_y
);

  logic signed [31:0] scale_r, xoff_r, yoff_r;
  logic signed [30:0] start_r, end_r;
  logic [11:0]        seg_r;

  logic [11:0]        i_r, n_r, n_eff, i_eff;
  logic signed [43:0] diff_r;
  logic signed [63:0] t40_r, t2_r, w_r, tmp_r, tc_r, ts_r, sc_r, ss_r;
  logic signed [31:0] px_r, py_r, out_x_r, out_y_r;
  logic signed [31:0] min_x_r, min_y_r, max_x_r, max_y_r;
  logic               div_neg_r, simple_done_r, out_valid_r;

  logic signed [63:0] mul_a, mul_b, mul_p;
  logic               mul_start, mul_done;
  logic [63:0]        div_n, div_q;
  logic [clpg_pkg::DVS_W-1:0] div_d;
  logic               div_start, div_done, div_neg;
  logic [63:0]        tmp_mag;
  logic [71:0]        kprod;
  logic signed [63:0] qs, qn, t_sum, t_clamp;
  logic signed [31:0] finx, finy;
  logic signed [31:0] span;
  logic signed [44:0] diff_full;

  function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
    if (v > 65'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -65'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= 32'sd65536;
      xoff_r  <= '0;
      yoff_r  <= '0;
      start_r <= '0;
      end_r   <= 31'sd268435456;
      seg_r   <= 12'd64;
    end else if (cfg_we) begin
      case (clpg_pkg::cfg_reg_t'(cfg_idx))
        clpg_pkg::REG_SCALE:    scale_r <= cfg_data;
        clpg_pkg::REG_X_OFFSET: xoff_r  <= cfg_data;
        clpg_pkg::REG_Y_OFFSET: yoff_r  <= cfg_data;
        clpg_pkg::REG_START:    start_r <= cfg_data[30:0];
        clpg_pkg::REG_END:      end_r   <= cfg_data[30:0];
        clpg_pkg::REG_SEGMENTS: seg_r   <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    n_eff = (seg_r == 12'd0) ? 12'd1 : seg_r;
    if (32'(n_eff) > 32'(clpg_pkg::MAX_SEGMENTS)) n_eff = 12'(clpg_pkg::MAX_SEGMENTS);
    i_eff = (sample_index > n_eff) ? n_eff : sample_index;
  end

  // operand selection
  always_comb begin
    case (cmd.uop.asel)
      clpg_pkg::A_T40:   mul_a = t40_r;
      clpg_pkg::A_T2:    mul_a = t2_r;
      clpg_pkg::A_TMP:   mul_a = tmp_r;
      clpg_pkg::A_TC:    mul_a = tc_r;
      clpg_pkg::A_TS:    mul_a = ts_r;
      clpg_pkg::A_SCALE: mul_a = 64'(scale_r);
      default:           mul_a = tmp_r;
    endcase
    case (cmd.uop.bsel)
      clpg_pkg::B_T40: mul_b = t40_r;
      clpg_pkg::B_T2:  mul_b = t2_r;
      clpg_pkg::B_HP:  mul_b = clpg_pkg::HALF_PI_Q40;
      clpg_pkg::B_W:   mul_b = w_r;
      clpg_pkg::B_SC:  mul_b = sc_r;
      clpg_pkg::B_SS:  mul_b = ss_r;
      default:         mul_b = clpg_pkg::HALF_PI_Q40;
    endcase
  end

  always_comb begin
    tmp_mag   = tmp_r[63] ? 64'(-tmp_r) : 64'(tmp_r);
    mul_start = cmd.start && (cmd.uop.op == clpg_pkg::OP_MUL);
    div_start = 1'b0;
    div_n     = tmp_mag;
    div_d     = clpg_pkg::DVS_W'(3);
    div_neg   = tmp_r[63];
    kprod     = 72'(tmp_mag) * 72'(clpg_pkg::coef_c(cmd.k));
    case (cmd.uop.op)
      clpg_pkg::OP_TDIV: begin
        div_start = cmd.start;
        div_n     = diff_r[43] ? 64'(-diff_r) : 64'(diff_r);
        div_d     = clpg_pkg::DVS_W'(n_r);
        div_neg   = diff_r[43];
      end
      clpg_pkg::OP_DIV3: div_start = cmd.start;
      clpg_pkg::OP_KDIVC: begin
        div_start = cmd.start;
        div_n     = kprod[63:0];
        div_d     = clpg_pkg::den_c(cmd.k);
      end
      clpg_pkg::OP_KDIVS: begin
        div_start = cmd.start;
        kprod     = 72'(tmp_mag) * 72'(clpg_pkg::coef_s(cmd.k));
        div_n     = kprod[63:0];
        div_d     = clpg_pkg::den_s(cmd.k);
      end
      default: ;
    endcase
  end

  clpg_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .product (mul_p),
    .done    (mul_done)
  );

  clpg_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_n),
    .divisor  (div_d),
    .quotient (div_q),
    .done     (div_done)
  );

  // results of the current step
  always_comb begin
    span      = 32'(end_r) - 32'(start_r);
    diff_full = span * $signed({1'b0, i_r});
    qs        = div_neg_r ? -$signed(div_q) : $signed(div_q);
    qn        = -qs;
    t_sum     = 64'(start_r) + qs;
    if (t_sum > clpg_pkg::T_LIMIT) t_clamp = clpg_pkg::T_LIMIT;
    else if (t_sum < -clpg_pkg::T_LIMIT) t_clamp = -clpg_pkg::T_LIMIT;
    else t_clamp = t_sum;
    finx = sat32(65'(tmp_r) + 65'(xoff_r));
    finy = sat32(65'(tmp_r) + 65'(yoff_r));
    case (cmd.uop.op)
      clpg_pkg::OP_MUL:   st.done = mul_done;
      clpg_pkg::OP_TDIV,
      clpg_pkg::OP_DIV3,
      clpg_pkg::OP_KDIVC,
      clpg_pkg::OP_KDIVS: st.done = div_done;
      default:            st.done = simple_done_r;
    endcase
    st.out_free = !out_valid_r || out_ready;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      i_r <= i_eff;
      n_r <= n_eff;
    end
    if (div_start) div_neg_r <= div_neg;
    if (cmd.start) begin
      case (cmd.uop.op)
        clpg_pkg::OP_DIFF: diff_r <= diff_full[43:0];
        clpg_pkg::OP_FINX: px_r   <= finx;
        clpg_pkg::OP_FINY: py_r   <= finy;
        default: ;
      endcase
    end
    if (st.done) begin
      case (cmd.uop.op)
        clpg_pkg::OP_MUL: begin
          case (cmd.uop.dst)
            clpg_pkg::D_T2:  t2_r  <= mul_p;
            clpg_pkg::D_W:   w_r   <= mul_p;
            default:         tmp_r <= mul_p;
          endcase
        end
        clpg_pkg::OP_TDIV: t40_r <= t_clamp <<< 12;
        clpg_pkg::OP_DIV3: begin
          ts_r <= qs;
          ss_r <= qs;
          tc_r <= t40_r;
          sc_r <= t40_r;
        end
        clpg_pkg::OP_KDIVC: begin
          tc_r <= qn;
          sc_r <= sc_r + qn;
        end
        clpg_pkg::OP_KDIVS: begin
          ts_r <= qn;
          ss_r <= ss_r + qn;
        end
        default: ;
      endcase
    end
    if (cmd.emit) begin
      out_x_r <= px_r;
      out_y_r <= py_r;
    end
  end

  // bounding box and output handshake
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      simple_done_r <= 1'b0;
      out_valid_r   <= 1'b0;
      min_x_r       <= '0;
      min_y_r       <= '0;
      max_x_r       <= '0;
      max_y_r       <= '0;
    end else begin
      simple_done_r <= cmd.start && (cmd.uop.op == clpg_pkg::OP_DIFF ||
                                     cmd.uop.op == clpg_pkg::OP_FINX ||
                                     cmd.uop.op == clpg_pkg::OP_FINY);
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
        if (i_r == 12'd0) begin
          min_x_r <= px_r;
          max_x_r <= px_r;
          min_y_r <= py_r;
          max_y_r <= py_r;
        end else begin
          if (px_r < min_x_r) min_x_r <= px_r;
          if (py_r < min_y_r) min_y_r <= py_r;
          if (px_r > max_x_r) max_x_r <= px_r;
          if (py_r > max_y_r) max_y_r <= py_r;
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign point_x   = out_x_r;
  assign point_y   = out_y_r;
  assign box_min_x = min_x_r;
  assign box_min_y = min_y_r;
  assign box_max_x = max_x_r;
  assign box_max_y = max_y_r;

endmodule

/* design/clpg_ctrl.sv */
`timescale 1ns / 1ps
// clpg_ctrl: sequencer that steps the datapath through the microcode, series loop included
// depends on clpg_pkg

module clpg_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output clpg_pkg::ctl_cmd_t cmd,
  input  clpg_pkg::dp_stat_t st
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_ISSUE = 4'b0010,
    S_WAIT  = 4'b0100,
    S_EMIT  = 4'b1000
  } state_t;

  state_t                      state_r, state_nxt;
  logic [clpg_pkg::PC_W-1:0]   pc_r, pc_nxt;
  logic [clpg_pkg::KW-1:0]     k_r, k_nxt;

  always_comb begin
    state_nxt = state_r;
    pc_nxt    = pc_r;
    k_nxt     = k_r;
    cmd.load  = 1'b0;
    cmd.start = 1'b0;
    cmd.emit  = 1'b0;
    cmd.uop   = clpg_pkg::ucode(pc_r);
    cmd.k     = k_r;
    in_ready  = (state_r == S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          pc_nxt    = '0;
          k_nxt     = '0;
          state_nxt = S_ISSUE;
        end
      end
      S_ISSUE: begin
        cmd.start = 1'b1;
        state_nxt = S_WAIT;
      end
      S_WAIT: begin
        if (st.done) begin
          if (pc_r == clpg_pkg::PC_LAST) begin
            state_nxt = S_EMIT;
          end else begin
            state_nxt = S_ISSUE;
            if (pc_r == clpg_pkg::PC_LOOP_END && k_r != clpg_pkg::K_LAST) begin
              k_nxt  = k_r + 1'b1;
              pc_nxt = clpg_pkg::PC_LOOP;
            end else begin
              pc_nxt = pc_r + 1'b1;
            end
          end
        end
      end
      S_EMIT: begin
        if (st.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pc_r    <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
      k_r     <= k_nxt;
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_ISSUE && pc_r == '0))
    else $error("transfer did not start the sequence");

  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    st.done |-> (state_r == S_WAIT))
    else $error("unit finished outside a wait");

  a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
    pc_r <= clpg_pkg::PC_LAST)
    else $error("microcode address out of range");

  a_k_range: assert property (@(posedge clk) disable iff (!rst_n)
    k_r <= clpg_pkg::K_LAST)
    else $error("term counter past last term");

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// tb: self-checking bench for clothoid_point_generator_top, predicts every point and box
// depends on clpg_pkg, clpg_if and the design files of the block

module tb;

  localparam logic [clpg_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [clpg_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
  localparam int LIMIT_CYCLES = 20000000;
  localparam int DRAIN_CYCLES = 2000;
  localparam int HOLD_CYCLES = 4000;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct {
    logic signed [31:0] px, py, min_x, min_y, max_x, max_y;
  } curve_point_t;

  logic clk, rst_n;
  logic cfg_we;
  logic [clpg_pkg::CFG_IDX_W-1:0] cfg_idx;
  logic [31:0] cfg_data;

  clpg_in_if in_ch ();
  clpg_out_if out_ch ();

  clothoid_point_generator_top dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .in_ch(in_ch), .out_ch(out_ch)
  );

  // shadow registers and box
  longint scale_r, x_off, y_off, start_t, end_t;
  logic [11:0] seg_cnt;
  logic signed [31:0] box_min_x, box_min_y, box_max_x, box_max_y;

  logic [11:0] pending_idx[$];
  curve_point_t expected_pts[$];
  idle_mode_t idle_mode;
  int mismatches, cycles, hold_reqs, hold_served, hold_left;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic longint fx_mul(input longint a, input longint b);
    logic [63:0] ma, mb, r;
    logic [127:0] p;
    ma = (a < 0) ? 64'(-a) : 64'(a);
    mb = (b < 0) ? 64'(-b) : 64'(b);
    p = {64'b0, ma} * {64'b0, mb};
    r = p[103:40];
    if (r[63]) r = 64'h7fff_ffff_ffff_ffff;
    return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
  endfunction

  function automatic logic signed [31:0] sat32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7fff_ffff;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic curve_point_t next_point(input logic [11:0] idx);
    longint n, i, q, t, t40, t2, t4, w, tc, ts, sc, ss, kk;
    curve_point_t r;
    n = (seg_cnt == 0) ? 1 : longint'(seg_cnt);
    if (n > clpg_pkg::MAX_SEGMENTS) n = clpg_pkg::MAX_SEGMENTS;
    i = (longint'(idx) > n) ? n : longint'(idx);
    q = ((end_t - start_t) * i) / n;
    t = start_t + q;
    if (t > clpg_pkg::T_LIMIT) t = clpg_pkg::T_LIMIT;
    if (t < -clpg_pkg::T_LIMIT) t = -clpg_pkg::T_LIMIT;
    t40 = t * 4096;
    t2 = fx_mul(t40, t40);
    t4 = fx_mul(t2, t2);
    w = fx_mul(fx_mul(t4, clpg_pkg::HALF_PI_Q40), clpg_pkg::HALF_PI_Q40);
    tc = t40;
    ts = fx_mul(fx_mul(t2, t40), clpg_pkg::HALF_PI_Q40) / 3;
    sc = tc;
    ss = ts;
    for (int k = 0; k < clpg_pkg::TERMS - 1; k++) begin
      kk = k;
      tc = -((fx_mul(tc, w) * (4 * kk + 1)) / ((2 * kk + 1) * (2 * kk + 2) * (4 * kk + 5)));
      ts = -((fx_mul(ts, w) * (4 * kk + 3)) / ((2 * kk + 2) * (2 * kk + 3) * (4 * kk + 7)));
      sc += tc;
      ss += ts;
    end
    r.px = sat32(fx_mul(scale_r, sc) + x_off);
    r.py = sat32(fx_mul(scale_r, ss) + y_off);
    if (i == 0) begin
      box_min_x = r.px;
      box_max_x = r.px;
      box_min_y = r.py;
      box_max_y = r.py;
    end else begin
      if (r.px < box_min_x) box_min_x = r.px;
      if (r.py < box_min_y) box_min_y = r.py;
      if (r.px > box_max_x) box_max_x = r.px;
      if (r.py > box_max_y) box_max_y = r.py;
    end
    r.min_x = box_min_x;
    r.min_y = box_min_y;
    r.max_x = box_max_x;
    r.max_y = box_max_y;
    return r;
  endfunction

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        expected_pts = {expected_pts, next_point(in_ch.sample_index)};
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_idx.size() > 0 &&
            !((idle_mode == IDLE_SENDER && $urandom_range(99) < 85) ||
              (idle_mode == IDLE_BOTH && $urandom_range(99) < 25))) begin
          in_ch.valid <= 1'b1;
          in_ch.sample_index <= pending_idx.pop_front();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_served <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_reqs) begin
      hold_left <= HOLD_CYCLES;
      hold_served <= hold_served + 1;
    end
  end

  // result monitor
  always @(posedge clk) begin
    curve_point_t e;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_pts.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected transfer at cycle %0d", cycles);
        end else begin
          e = expected_pts.pop_front();
          if (out_ch.point_x !== e.px || out_ch.point_y !== e.py ||
              out_ch.box_min_x !== e.min_x || out_ch.box_min_y !== e.min_y ||
              out_ch.box_max_x !== e.max_x || out_ch.box_max_y !== e.max_y) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch cycle %0d exp %0d %0d box %0d %0d %0d %0d",
                        " got %0d %0d box %0d %0d %0d %0d"},
                       cycles, e.px, e.py, e.min_x, e.min_y, e.max_x, e.max_y,
                       out_ch.point_x, out_ch.point_y, out_ch.box_min_x, out_ch.box_min_y,
                       out_ch.box_max_x, out_ch.box_max_y);
          end
        end
      end
      out_ch.ready <= !((hold_left > 0) ||
                        (idle_mode == IDLE_RECEIVER && $urandom_range(99) < 85) ||
                        (idle_mode == IDLE_BOTH && $urandom_range(99) < 25));
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("tb failed");
      $finish;
    end
  end

  task automatic write_reg(input logic [clpg_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    case (idx)
      clpg_pkg::REG_SCALE: scale_r = longint'($signed(val));
      clpg_pkg::REG_X_OFFSET: x_off = longint'($signed(val));
      clpg_pkg::REG_Y_OFFSET: y_off = longint'($signed(val));
      clpg_pkg::REG_START: start_t = longint'($signed(val[30:0]));
      clpg_pkg::REG_END: end_t = longint'($signed(val[30:0]));
      clpg_pkg::REG_SEGMENTS: seg_cnt = val[11:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (pending_idx.size() > 0 || in_ch.valid || expected_pts.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic random_setup();
    logic [31:0] v;
    v = $urandom_range(3) == 0 ? $urandom() : $urandom_range(1 << 20);
    write_reg(clpg_pkg::REG_SCALE, $urandom_range(1) ? v : -v);
    write_reg(clpg_pkg::REG_X_OFFSET,
              $urandom_range(3) == 0 ? $urandom() : $urandom_range(1 << 20));
    write_reg(clpg_pkg::REG_Y_OFFSET,
              $urandom_range(3) == 0 ? $urandom() : -$urandom_range(1 << 20));
    write_reg(clpg_pkg::REG_START, $urandom_range(5) == 0 ? $urandom() :
              32'($urandom_range(1 << 30)) - 32'(1 << 29));
    write_reg(clpg_pkg::REG_END, $urandom_range(5) == 0 ? $urandom() :
              32'($urandom_range(1 << 30)) - 32'(1 << 29));
    write_reg(clpg_pkg::REG_SEGMENTS,
              $urandom_range(7) == 0 ? $urandom_range(4095) : $urandom_range(40));
  endtask

  task automatic random_items(input int count);
    int n, j;
    n = (seg_cnt == 0) ? 1 : int'(seg_cnt);
    j = 0;
    while (j < count) begin
      if ($urandom_range(4) == 0) begin
        pending_idx = {pending_idx, 12'($urandom())};
        j++;
      end else begin
        pending_idx = {pending_idx, 12'd0};
        j++;
        for (int s = 1; s <= n + 1 && j < count && s < 20; s++) begin
          pending_idx = {pending_idx,
                         $urandom_range(3) == 0 ? 12'($urandom_range(n + 2)) : 12'(s)};
          j++;
        end
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.sample_index = '0;
    out_ch.ready = 1'b0;
    idle_mode = IDLE_NONE;
    mismatches = 0;
    cycles = 0;
    hold_reqs = 0;
    scale_r = 65536;
    x_off = 0;
    y_off = 0;
    start_t = 0;
    end_t = 268435456;
    seg_cnt = 64;
    box_min_x = 0;
    box_min_y = 0;
    box_max_x = 0;
    box_max_y = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // box before index zero, past end, defaults
    pending_idx = '{12'd5, 12'd0, 12'd1, 12'd64, 12'd65, 12'd4095, 12'd32};
    drain();
    // extremes, clamped parameter, saturation, spare indexes ignored
    write_reg(clpg_pkg::REG_SCALE, 32'h7fff_ffff);
    write_reg(clpg_pkg::REG_X_OFFSET, 32'h7fff_ffff);
    write_reg(clpg_pkg::REG_Y_OFFSET, 32'h8000_0000);
    write_reg(clpg_pkg::REG_START, 32'h4000_0000);
    write_reg(clpg_pkg::REG_END, 32'h3fff_ffff);
    write_reg(clpg_pkg::REG_SEGMENTS, 32'd4095);
    write_reg(REG_SPARE_LO, 32'hffff_ffff);
    write_reg(REG_SPARE_HI, 32'h0);
    pending_idx = '{12'd0, 12'd4095, 12'd2048, 12'd1, 12'd1365};
    drain();
    write_reg(clpg_pkg::REG_SCALE, 32'h8000_0000);
    write_reg(clpg_pkg::REG_X_OFFSET, 32'h0);
    write_reg(clpg_pkg::REG_Y_OFFSET, 32'h0);
    write_reg(clpg_pkg::REG_START, 32'h2000_0000);
    write_reg(clpg_pkg::REG_END, 32'h6000_0000);
    write_reg(clpg_pkg::REG_SEGMENTS, 32'd0);
    pending_idx = '{12'd0, 12'd1, 12'd2, 12'hfff};
    drain();
    write_reg(clpg_pkg::REG_SCALE, 32'h0001_0000);
    write_reg(clpg_pkg::REG_START, 32'h6000_0000);
    write_reg(clpg_pkg::REG_END, 32'h2000_0000);
    write_reg(clpg_pkg::REG_SEGMENTS, 32'd3);
    pending_idx = '{12'd0, 12'd1, 12'd2, 12'd3, 12'd7};
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      idle_mode = idle_mode_t'(ph % 4);
      random_setup();
      if (ph == 2) hold_reqs++;
      random_items(128);
      drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_pts.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end
endmodule

/* clothoid_point_generator_top.f */
design/clpg_pkg.sv
design/clpg_if.sv
design/clpg_mul.sv
design/clpg_div.sv
design/clpg_dp.sv
design/clpg_ctrl.sv
design/clothoid_point_generator_top.sv
tb/tb.sv
